// File: rtl/core/ptbt_pkg.sv
// Pan/tilt ball tracker package: item and state types, grid, servo and action constants.
// No dependencies; used by the interfaces, ptbt_step and pan_tilt_ball_tracker.
package ptbt_pkg;

  typedef logic [9:0]         pos_t;
  typedef logic signed [11:0] wide_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_LEFT    = 3'd1,
    ACT_RIGHT   = 3'd2,
    ACT_FORWARD = 3'd5,
    ACT_KICK    = 3'd6
  } action_e;

  typedef enum logic [3:0] {
    CELL_NONE = 4'd0,
    CELL_TL   = 4'd1,
    CELL_TC   = 4'd2,
    CELL_TR   = 4'd3,
    CELL_ML   = 4'd4,
    CELL_MC   = 4'd5,
    CELL_MR   = 4'd6,
    CELL_BL   = 4'd7,
    CELL_BC   = 4'd8,
    CELL_BR   = 4'd9
  } cell_e;

  typedef struct packed {
    logic [9:0]  centroid_x;
    logic [8:0]  centroid_y;
    logic [18:0] blob_area;
  } in_item_t;

  typedef struct packed {
    logic [9:0] pan_goal;
    logic [9:0] tilt_goal;
    action_e    action_code;
    logic       ball_found;
  } out_item_t;

  typedef struct packed {
    pos_t              pan_pos;
    pos_t              tilt_pos;
    logic signed [5:0] pan_step;
    logic signed [4:0] tilt_step;
    logic [2:0]        bounce_count;
    cell_e             last_cell;
    action_e           action;
  } state_t;

  // grid bands
  localparam logic [9:0] COL_A = 10'd213;
  localparam logic [9:0] COL_B = 10'd426;
  localparam logic [9:0] COL_C = 10'd640;
  localparam logic [8:0] ROW_A = 9'd160;
  localparam logic [8:0] ROW_B = 9'd320;
  localparam logic [8:0] ROW_C = 9'd480;

  // servo limits and aim points
  localparam pos_t PAN_MIN     = 10'd382;
  localparam pos_t PAN_MAX     = 10'd642;
  localparam pos_t PAN_HOME    = 10'd512;
  localparam pos_t AIM_LEFT    = 10'd482;
  localparam pos_t AIM_RIGHT   = 10'd542;
  localparam pos_t TILT_MAX    = 10'd510;
  localparam pos_t TILT_MIN    = 10'd259;
  localparam pos_t TILT_AIM    = 10'd260;
  localparam pos_t TILT_FLOOR  = 10'd230;
  localparam pos_t TILT_HOME   = 10'd390;
  localparam pos_t TILT_ROW_HI = 10'd430;
  localparam pos_t TILT_ROW_LO = 10'd350;
  localparam pos_t TILT_RESET  = 10'd490;

  localparam logic signed [5:0] PAN_STEP_TRACK  = 6'sd20;
  localparam logic signed [5:0] PAN_STEP_SWEEP  = 6'sd10;
  localparam logic signed [4:0] TILT_STEP_TRACK = 5'sd15;
  localparam logic signed [4:0] TILT_STEP_SWEEP = 5'sd10;

  localparam logic [2:0]  BOUNCE_LIMIT  = 3'd4;
  localparam logic [18:0] THRESH_RESET  = 19'd100;

endpackage

// File: rtl/core/ptbt_in_if.sv
// Input channel of the ball tracker: valid/ready plus one frame item.
// Depends on ptbt_pkg.
interface ptbt_in_if;
  logic                valid;
  logic                ready;
  ptbt_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/ptbt_out_if.sv
// Result channel of the ball tracker: valid/ready plus servo goals and action.
// Depends on ptbt_pkg.
interface ptbt_out_if;
  logic                valid;
  logic                ready;
  ptbt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/pan_tilt_ball_tracker.sv
// Pan/tilt ball tracker top level: input register, tracker state, result register.
// Depends on ptbt_pkg, ptbt_in_if, ptbt_out_if and ptbt_step.
//
//   channel   dir   handshake     payload
//   in_i      in    valid/ready   centroid_x, centroid_y, blob_area
//   out_o     out   valid/ready   pan_goal, tilt_goal, action_code, ball_found
//   cfg       in    cfg_we_i      cfg_wdata_i = area_threshold
//
// An accepted item passes through the input register and then the result register; one item per cycle
// sustained while the result is taken, the state update between the two registers being combinational.
// Reset restores the servo goals, steps and threshold at once, no clearing pass.
// A stalled result holds the pipe; the input register still fills behind it.
module pan_tilt_ball_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [18:0]       cfg_wdata_i,
  ptbt_in_if.sink           in_i,
  ptbt_out_if.source        out_o
);

  logic                s1_valid_q;
  ptbt_pkg::in_item_t  s1_data_q;
  logic                out_valid_q;
  ptbt_pkg::out_item_t out_data_q;
  ptbt_pkg::state_t    state_q;
  ptbt_pkg::state_t    state_d;
  ptbt_pkg::out_item_t res_d;
  logic [18:0]         thr_q;
  logic                adv;
  logic                in_ready;

  assign adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || adv;

  ptbt_step u_step (
    .cur_i  (state_q),
    .thr_i  (thr_q),
    .item_i (s1_data_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= ptbt_pkg::THRESH_RESET;
      state_q     <= '{pan_pos:      ptbt_pkg::PAN_HOME,
                       tilt_pos:     ptbt_pkg::TILT_RESET,
                       pan_step:     ptbt_pkg::PAN_STEP_TRACK,
                       tilt_step:    '0,
                       bounce_count: '0,
                       last_cell:    ptbt_pkg::CELL_NONE,
                       action:       ptbt_pkg::ACT_NONE};
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_data_q <= in_i.data;
    end
    if (adv) begin
      out_data_q <= res_d;
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_pan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pan_pos >= ptbt_pkg::PAN_MIN && state_q.pan_pos <= ptbt_pkg::PAN_MAX)
    else $error("pan goal out of range");

  a_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tilt_pos >= ptbt_pkg::TILT_FLOOR && state_q.tilt_pos <= ptbt_pkg::TILT_MAX)
    else $error("tilt goal out of range");

  a_bounce_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bounce_count <= ptbt_pkg::BOUNCE_LIMIT)
    else $error("bounce count past limit");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q && out_data_q.pan_goal == state_q.pan_pos
            && out_data_q.tilt_goal == state_q.tilt_pos)
    else $error("result does not match updated state");
`endif

endmodule

// File: rtl/core/ptbt_step.sv
// Next-state logic for one frame: grid lookup, tracking step and search sweep.
// Depends on ptbt_pkg.
module ptbt_step (
  input  ptbt_pkg::state_t    cur_i,
  input  logic [18:0]         thr_i,
  input  ptbt_pkg::in_item_t  item_i,
  output ptbt_pkg::state_t    nxt_o,
  output ptbt_pkg::out_item_t res_o
);

  function automatic ptbt_pkg::wide_t ext_pos(ptbt_pkg::pos_t v);
    return $signed({2'b00, v});
  endfunction

  function automatic ptbt_pkg::action_e side_action(ptbt_pkg::pos_t pan,
                                                    ptbt_pkg::action_e centre);
    if (pan < ptbt_pkg::AIM_LEFT) begin
      return ptbt_pkg::ACT_RIGHT;
    end else if (pan > ptbt_pkg::AIM_RIGHT) begin
      return ptbt_pkg::ACT_LEFT;
    end
    return centre;
  endfunction

  logic              found;
  logic [1:0]        col;
  logic [1:0]        row;
  logic              in_grid;
  ptbt_pkg::cell_e   grid_cell;
  ptbt_pkg::cell_e   sel_cell;
  ptbt_pkg::state_t  nxt;
  ptbt_pkg::wide_t   pan_w;
  ptbt_pkg::wide_t   tilt_w;

  assign found = item_i.blob_area >= thr_i;

  always_comb begin
    col = 2'd3;
    if (item_i.centroid_x <= ptbt_pkg::COL_A) begin
      col = 2'd0;
    end else if (item_i.centroid_x <= ptbt_pkg::COL_B) begin
      col = 2'd1;
    end else if (item_i.centroid_x <= ptbt_pkg::COL_C) begin
      col = 2'd2;
    end
    row = 2'd3;
    if (item_i.centroid_y <= ptbt_pkg::ROW_A) begin
      row = 2'd0;
    end else if (item_i.centroid_y <= ptbt_pkg::ROW_B) begin
      row = 2'd1;
    end else if (item_i.centroid_y <= ptbt_pkg::ROW_C) begin
      row = 2'd2;
    end
    in_grid = (col != 2'd3) && (row != 2'd3);
    unique case ({row, col})
      4'b0000: grid_cell = ptbt_pkg::CELL_TL;
      4'b0001: grid_cell = ptbt_pkg::CELL_TC;
      4'b0010: grid_cell = ptbt_pkg::CELL_TR;
      4'b0100: grid_cell = ptbt_pkg::CELL_ML;
      4'b0101: grid_cell = ptbt_pkg::CELL_MC;
      4'b0110: grid_cell = ptbt_pkg::CELL_MR;
      4'b1000: grid_cell = ptbt_pkg::CELL_BL;
      4'b1001: grid_cell = ptbt_pkg::CELL_BC;
      4'b1010: grid_cell = ptbt_pkg::CELL_BR;
      default: grid_cell = ptbt_pkg::CELL_NONE;
    endcase
    sel_cell = in_grid ? grid_cell : cur_i.last_cell;
  end

  always_comb begin
    nxt    = cur_i;
    pan_w  = '0;
    tilt_w = '0;
    if (found) begin
      nxt.last_cell = sel_cell;
      if (sel_cell == ptbt_pkg::CELL_MC) begin
        nxt.pan_step  = '0;
        nxt.tilt_step = '0;
        nxt.action    = (cur_i.tilt_pos > ptbt_pkg::TILT_AIM) ?
                        side_action(cur_i.pan_pos, ptbt_pkg::ACT_FORWARD) :
                        ptbt_pkg::ACT_KICK;
      end else begin
        case (sel_cell) inside
          ptbt_pkg::CELL_TL, ptbt_pkg::CELL_TC, ptbt_pkg::CELL_TR:
            nxt.tilt_step = ptbt_pkg::TILT_STEP_TRACK;
          ptbt_pkg::CELL_ML, ptbt_pkg::CELL_MR:
            nxt.tilt_step = '0;
          ptbt_pkg::CELL_BL, ptbt_pkg::CELL_BC, ptbt_pkg::CELL_BR:
            nxt.tilt_step = -ptbt_pkg::TILT_STEP_TRACK;
          default: nxt.tilt_step = cur_i.tilt_step;
        endcase
        case (sel_cell) inside
          ptbt_pkg::CELL_TL, ptbt_pkg::CELL_ML, ptbt_pkg::CELL_BL:
            nxt.pan_step = ptbt_pkg::PAN_STEP_TRACK;
          ptbt_pkg::CELL_TC, ptbt_pkg::CELL_BC:
            nxt.pan_step = '0;
          ptbt_pkg::CELL_TR, ptbt_pkg::CELL_MR, ptbt_pkg::CELL_BR:
            nxt.pan_step = -ptbt_pkg::PAN_STEP_TRACK;
          default: nxt.pan_step = cur_i.pan_step;
        endcase
      end
      tilt_w = ext_pos(cur_i.tilt_pos) + ptbt_pkg::wide_t'(nxt.tilt_step);
      pan_w  = ext_pos(cur_i.pan_pos) + ptbt_pkg::wide_t'(nxt.pan_step);
      if (pan_w < ext_pos(ptbt_pkg::PAN_MIN)) begin
        nxt.pan_pos = ptbt_pkg::PAN_MIN;
        nxt.action  = ptbt_pkg::ACT_RIGHT;
      end else if (pan_w > ext_pos(ptbt_pkg::PAN_MAX)) begin
        nxt.pan_pos = ptbt_pkg::PAN_MAX;
        nxt.action  = ptbt_pkg::ACT_LEFT;
      end else begin
        nxt.pan_pos = pan_w[9:0];
      end
      if (tilt_w > ext_pos(ptbt_pkg::TILT_MAX)) begin
        nxt.tilt_pos = ptbt_pkg::TILT_MAX;
      end else if (tilt_w < ext_pos(ptbt_pkg::TILT_MIN)) begin
        nxt.tilt_pos = ptbt_pkg::TILT_MIN;
        nxt.action   = side_action(nxt.pan_pos, ptbt_pkg::ACT_KICK);
      end else begin
        nxt.tilt_pos = tilt_w[9:0];
      end
      nxt.bounce_count = '0;
    end else begin
      if (cur_i.bounce_count < ptbt_pkg::BOUNCE_LIMIT) begin
        pan_w = ext_pos(cur_i.pan_pos) + ptbt_pkg::wide_t'(cur_i.pan_step);
        if (pan_w < ext_pos(ptbt_pkg::PAN_MIN)) begin
          nxt.pan_pos      = ptbt_pkg::PAN_MIN;
          nxt.pan_step     = -cur_i.pan_step;
          nxt.bounce_count = cur_i.bounce_count + 3'd1;
          tilt_w = ext_pos((cur_i.pan_step < 0) ? ptbt_pkg::TILT_ROW_HI :
                                                  ptbt_pkg::TILT_ROW_LO)
                   + ptbt_pkg::wide_t'(cur_i.tilt_step);
          nxt.tilt_pos = tilt_w[9:0];
        end else if (pan_w > ext_pos(ptbt_pkg::PAN_MAX)) begin
          nxt.pan_pos      = ptbt_pkg::PAN_MAX;
          nxt.pan_step     = -cur_i.pan_step;
          nxt.bounce_count = cur_i.bounce_count + 3'd1;
          nxt.tilt_pos     = (cur_i.pan_step < 0) ? ptbt_pkg::TILT_ROW_HI :
                                                    ptbt_pkg::TILT_ROW_LO;
        end else begin
          nxt.pan_pos = pan_w[9:0];
        end
        nxt.action = ptbt_pkg::ACT_NONE;
      end else begin
        nxt.pan_pos      = ptbt_pkg::PAN_HOME;
        nxt.tilt_pos     = ptbt_pkg::TILT_HOME;
        nxt.bounce_count = '0;
        nxt.pan_step     = ptbt_pkg::PAN_STEP_SWEEP;
        nxt.tilt_step    = ptbt_pkg::TILT_STEP_SWEEP;
        nxt.action       = ptbt_pkg::ACT_LEFT;
      end
      // tilt creep of the sweep
      if (nxt.tilt_step == -ptbt_pkg::TILT_STEP_SWEEP) begin
        tilt_w = ext_pos(nxt.tilt_pos) - ptbt_pkg::wide_t'(ptbt_pkg::TILT_STEP_SWEEP);
        if (tilt_w <= ext_pos(ptbt_pkg::TILT_FLOOR)) begin
          nxt.tilt_pos = ptbt_pkg::TILT_FLOOR;
          if (nxt.pan_step == '0) begin
            nxt.pan_step = ptbt_pkg::PAN_STEP_SWEEP;
            nxt.tilt_pos = ptbt_pkg::TILT_HOME;
          end
        end else begin
          nxt.tilt_pos = tilt_w[9:0];
        end
      end else if (nxt.tilt_step == ptbt_pkg::TILT_STEP_SWEEP) begin
        tilt_w = ext_pos(nxt.tilt_pos) + ptbt_pkg::wide_t'(ptbt_pkg::TILT_STEP_SWEEP);
        if (tilt_w >= ext_pos(ptbt_pkg::TILT_MAX)) begin
          nxt.tilt_pos = ptbt_pkg::TILT_MAX;
          if (nxt.pan_step == '0) begin
            nxt.pan_step = -ptbt_pkg::PAN_STEP_SWEEP;
            nxt.tilt_pos = ptbt_pkg::TILT_HOME;
          end
        end else begin
          nxt.tilt_pos = tilt_w[9:0];
        end
      end
    end
  end

  assign nxt_o             = nxt;
  assign res_o.pan_goal    = nxt.pan_pos;
  assign res_o.tilt_goal   = nxt.tilt_pos;
  assign res_o.action_code = nxt.action;
  assign res_o.ball_found  = found;

endmodule

// File: test/testbench.sv
// Testbench for pan_tilt_ball_tracker: directed and random frames checked against a
// behavioral tracker model, with random valid/ready idling and a long result stall.
// Depends on ptbt_pkg, ptbt_in_if, ptbt_out_if and the pan_tilt_ball_tracker RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [18:0] cfg_wdata_i;

  ptbt_in_if  in_if ();
  ptbt_out_if out_if ();

  pan_tilt_ball_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // tracker model state
  ptbt_pkg::pos_t    trk_pan;
  ptbt_pkg::pos_t    trk_tilt;
  logic signed [5:0] trk_pan_step;
  logic signed [4:0] trk_tilt_step;
  logic [2:0]        trk_bounces;
  ptbt_pkg::cell_e   trk_cell;
  ptbt_pkg::action_e trk_action;
  logic [18:0]       trk_thresh;

  ptbt_pkg::out_item_t pending_goals[$];
  ptbt_pkg::out_item_t goal_item;
  int        mismatches;
  int        cycle_cnt;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_seq;
  int        hold_seen;
  int        hold_left;

  always #5ns clk_i = ~clk_i;

  function automatic int grid_band(int v, int a, int b, int c);
    if (v <= a) return 0;
    if (v <= b) return 1;
    if (v <= c) return 2;
    return -1;
  endfunction

  function automatic ptbt_pkg::action_e aim_action(int pan, ptbt_pkg::action_e centre);
    if (pan < int'(ptbt_pkg::AIM_LEFT)) return ptbt_pkg::ACT_RIGHT;
    if (pan > int'(ptbt_pkg::AIM_RIGHT)) return ptbt_pkg::ACT_LEFT;
    return centre;
  endfunction

  function automatic ptbt_pkg::out_item_t step_tracker(ptbt_pkg::in_item_t it);
    int                  col, row, pan, tilt, ps, ts, idx;
    logic                hit;
    ptbt_pkg::out_item_t res;
    hit  = (it.blob_area >= trk_thresh);
    pan  = int'(trk_pan);
    tilt = int'(trk_tilt);
    ps   = trk_pan_step;
    ts   = trk_tilt_step;
    if (hit) begin
      col = grid_band(int'(it.centroid_x), int'(ptbt_pkg::COL_A), int'(ptbt_pkg::COL_B),
                      int'(ptbt_pkg::COL_C));
      row = grid_band(int'(it.centroid_y), int'(ptbt_pkg::ROW_A), int'(ptbt_pkg::ROW_B),
                      int'(ptbt_pkg::ROW_C));
      if (col >= 0 && row >= 0) trk_cell = ptbt_pkg::cell_e'(row * 3 + col + 1);
      if (trk_cell == ptbt_pkg::CELL_MC) begin
        ps = 0;
        ts = 0;
        trk_action = (tilt > int'(ptbt_pkg::TILT_AIM)) ?
                     aim_action(pan, ptbt_pkg::ACT_FORWARD) : ptbt_pkg::ACT_KICK;
      end else if (trk_cell != ptbt_pkg::CELL_NONE) begin
        idx = int'(trk_cell) - 1;
        ts = (idx / 3 == 0) ? int'(ptbt_pkg::TILT_STEP_TRACK) :
             (idx / 3 == 1) ? 0 : -int'(ptbt_pkg::TILT_STEP_TRACK);
        ps = (idx % 3 == 0) ? int'(ptbt_pkg::PAN_STEP_TRACK) :
             (idx % 3 == 1) ? 0 : -int'(ptbt_pkg::PAN_STEP_TRACK);
      end
      tilt += ts;
      pan  += ps;
      if (pan < int'(ptbt_pkg::PAN_MIN)) begin
        pan = int'(ptbt_pkg::PAN_MIN);
        trk_action = ptbt_pkg::ACT_RIGHT;
      end else if (pan > int'(ptbt_pkg::PAN_MAX)) begin
        pan = int'(ptbt_pkg::PAN_MAX);
        trk_action = ptbt_pkg::ACT_LEFT;
      end
      if (tilt > int'(ptbt_pkg::TILT_MAX)) begin
        tilt = int'(ptbt_pkg::TILT_MAX);
      end else if (tilt < int'(ptbt_pkg::TILT_MIN)) begin
        tilt = int'(ptbt_pkg::TILT_MIN);
        trk_action = aim_action(pan, ptbt_pkg::ACT_KICK);
      end
      trk_bounces = '0;
    end else begin
      if (trk_bounces < ptbt_pkg::BOUNCE_LIMIT) begin
        pan += ps;
        if (pan < int'(ptbt_pkg::PAN_MIN)) begin
          pan = int'(ptbt_pkg::PAN_MIN);
          ps = -ps;
          trk_bounces++;
          tilt = ((ps > 0) ? int'(ptbt_pkg::TILT_ROW_HI) : int'(ptbt_pkg::TILT_ROW_LO)) + ts;
        end else if (pan > int'(ptbt_pkg::PAN_MAX)) begin
          pan = int'(ptbt_pkg::PAN_MAX);
          ps = -ps;
          trk_bounces++;
          tilt = (ps > 0) ? int'(ptbt_pkg::TILT_ROW_HI) : int'(ptbt_pkg::TILT_ROW_LO);
        end
        trk_action = ptbt_pkg::ACT_NONE;
      end else begin
        // four bounces without a ball: recenter and restart the sweep
        pan = int'(ptbt_pkg::PAN_HOME);
        tilt = int'(ptbt_pkg::TILT_HOME);
        trk_bounces = '0;
        ps = int'(ptbt_pkg::PAN_STEP_SWEEP);
        ts = int'(ptbt_pkg::TILT_STEP_SWEEP);
        trk_action = ptbt_pkg::ACT_LEFT;
      end
      if (ts == -int'(ptbt_pkg::TILT_STEP_SWEEP)) begin
        tilt -= int'(ptbt_pkg::TILT_STEP_SWEEP);
        if (tilt <= int'(ptbt_pkg::TILT_FLOOR)) begin
          tilt = int'(ptbt_pkg::TILT_FLOOR);
          if (ps == 0) begin
            ps = int'(ptbt_pkg::PAN_STEP_SWEEP);
            tilt = int'(ptbt_pkg::TILT_HOME);
          end
        end
      end else if (ts == int'(ptbt_pkg::TILT_STEP_SWEEP)) begin
        tilt += int'(ptbt_pkg::TILT_STEP_SWEEP);
        if (tilt >= int'(ptbt_pkg::TILT_MAX)) begin
          tilt = int'(ptbt_pkg::TILT_MAX);
          if (ps == 0) begin
            ps = -int'(ptbt_pkg::PAN_STEP_SWEEP);
            tilt = int'(ptbt_pkg::TILT_HOME);
          end
        end
      end
    end
    trk_pan       = ptbt_pkg::pos_t'(pan);
    trk_tilt      = ptbt_pkg::pos_t'(tilt);
    trk_pan_step  = 6'(ps);
    trk_tilt_step = 5'(ts);
    res.pan_goal    = trk_pan;
    res.tilt_goal   = trk_tilt;
    res.action_code = trk_action;
    res.ball_found  = hit;
    return res;
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [18:0] pick_area(logic hit);
    if (hit || trk_thresh == 0) return 19'($urandom_range(19'h7FFFF, trk_thresh));
    return 19'($urandom_range(trk_thresh - 1, 0));
  endfunction

  function automatic ptbt_pkg::in_item_t aimed_frame(int row, int col);
    ptbt_pkg::in_item_t it;
    it.centroid_x = 10'($urandom_range(
        col == 0 ? 0 : col == 1 ? ptbt_pkg::COL_A + 1 : ptbt_pkg::COL_B + 1,
        col == 0 ? ptbt_pkg::COL_A : col == 1 ? ptbt_pkg::COL_B : ptbt_pkg::COL_C));
    it.centroid_y = 9'($urandom_range(
        row == 0 ? 0 : row == 1 ? ptbt_pkg::ROW_A + 1 : ptbt_pkg::ROW_B + 1,
        row == 0 ? ptbt_pkg::ROW_A : row == 1 ? ptbt_pkg::ROW_B : ptbt_pkg::ROW_C));
    if ($urandom_range(19) == 0) begin
      it.centroid_x = 10'($urandom_range(1023, ptbt_pkg::COL_C + 1));
    end
    if ($urandom_range(19) == 0) begin
      it.centroid_y = 9'($urandom_range(511, ptbt_pkg::ROW_C + 1));
    end
    it.blob_area = '0;
    return it;
  endfunction

  task automatic send_frame(ptbt_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_goals.push_back(step_tracker(it));
  endtask

  task automatic send_xy(int x, int y, int area);
    ptbt_pkg::in_item_t it;
    it.centroid_x = 10'(x);
    it.centroid_y = 9'(y);
    it.blob_area  = 19'(area);
    send_frame(it);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (pending_goals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [18:0] value);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    trk_thresh = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random_frames(int n_items);
    int                 sent, run_len, row, col, kind;
    ptbt_pkg::in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        // steady tracking on one cell
        row = $urandom_range(2);
        col = $urandom_range(2);
        run_len = $urandom_range(20, 1);
        if (run_len > n_items - sent) run_len = n_items - sent;
        repeat (run_len) begin
          it = aimed_frame(row, col);
          it.blob_area = pick_area(1'b1);
          send_frame(it);
          sent++;
        end
      end else if (kind < 8) begin
        // lost ball, long runs reach the recenter
        run_len = $urandom_range(kind == 7 ? 150 : 30, 1);
        if (run_len > n_items - sent) run_len = n_items - sent;
        repeat (run_len) begin
          it = aimed_frame($urandom_range(2), $urandom_range(2));
          it.blob_area = pick_area(1'b0);
          send_frame(it);
          sent++;
        end
      end else begin
        run_len = $urandom_range(4, 1);
        if (run_len > n_items - sent) run_len = n_items - sent;
        repeat (run_len) begin
          it.centroid_x = 10'($urandom);
          it.centroid_y = 9'($urandom);
          it.blob_area  = 19'($urandom);
          send_frame(it);
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_xy(700, 100, 100);      // found but off grid before any cell
    send_xy(0, 0, 99);
    send_xy(0, 0, 100);
    send_xy(int'(ptbt_pkg::COL_A), int'(ptbt_pkg::ROW_A), 19'h7FFFF);
    send_xy(int'(ptbt_pkg::COL_A) + 1, int'(ptbt_pkg::ROW_A) + 1, 300);
    send_xy(int'(ptbt_pkg::COL_B), int'(ptbt_pkg::ROW_B), 300);
    send_xy(int'(ptbt_pkg::COL_B) + 1, int'(ptbt_pkg::ROW_B) + 1, 300);
    send_xy(int'(ptbt_pkg::COL_C), int'(ptbt_pkg::ROW_C), 300);
    send_xy(int'(ptbt_pkg::COL_C) + 1, 100, 300);
    send_xy(100, int'(ptbt_pkg::ROW_C) + 1, 300);
    send_xy(1023, 511, 300);
    send_xy(320, 0, 300);
    send_xy(0, 240, 300);
    send_xy(640, 240, 300);
    send_xy(0, 400, 300);
    send_xy(320, 400, 300);
    send_xy(640, 0, 300);
    send_xy(320, 240, 300);
    send_xy(0, 0, 0);
    send_xy(320, 240, 307200);
    send_xy(512, 256, 0);
    wait_drain();
  endtask

  task automatic test_threshold_extremes();
    write_threshold('0);
    run_random_frames(20);
    write_threshold(19'd307200);
    run_random_frames(20);
    write_threshold(19'h7FFFF);
    run_random_frames(20);
    wait_drain();
  endtask

  task automatic test_random_tracking(int snd_idle, int rcv_idle, logic [18:0] thresh);
    write_threshold(thresh);
    send_idle_pct = snd_idle;
    recv_idle_pct = rcv_idle;
    run_random_frames(200);
    wait_drain();
  endtask

  task automatic test_backpressure();
    ptbt_pkg::in_item_t it;
    write_threshold(ptbt_pkg::THRESH_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq <= hold_seq + 1;
    repeat (40) begin
      it = aimed_frame($urandom_range(2), $urandom_range(2));
      it.blob_area = pick_area(1'($urandom_range(1)));
      send_frame(it);
    end
    wait_drain();
  endtask

  // result ready, with a counted long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_goals.size() == 0) begin
        $display("%0t unexpected item expected none actual pan %0d tilt %0d action %0d",
                 $time, out_if.data.pan_goal, out_if.data.tilt_goal,
                 out_if.data.action_code);
        mismatches++;
      end else begin
        goal_item = pending_goals.pop_front();
        check_field("pan_goal", goal_item.pan_goal, out_if.data.pan_goal);
        check_field("tilt_goal", goal_item.tilt_goal, out_if.data.tilt_goal);
        check_field("action_code", goal_item.action_code, out_if.data.action_code);
        check_field("ball_found", goal_item.ball_found, out_if.data.ball_found);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    mismatches    = 0;
    cycle_cnt     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    trk_pan       = ptbt_pkg::PAN_HOME;
    trk_tilt      = ptbt_pkg::TILT_RESET;
    trk_pan_step  = ptbt_pkg::PAN_STEP_TRACK;
    trk_tilt_step = '0;
    trk_bounces   = '0;
    trk_cell      = ptbt_pkg::CELL_NONE;
    trk_action    = ptbt_pkg::ACT_NONE;
    trk_thresh    = ptbt_pkg::THRESH_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_threshold_extremes();
    test_random_tracking(35, 78, 19'd100);
    test_random_tracking(78, 35, 19'd5000);
    test_random_tracking(0, 0, 19'd307200);
    test_backpressure();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
